// ===== design/ushsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ushsp_pkg
// Shared constants and the queued result type of the ustar header parser.
// ----------------------------------------------------------------------------
package ushsp_pkg;

    // Result kinds as they appear on the result channel.
    localparam logic [1:0] KIND_ENTRY   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_TRUNC   = 2'd3;

    // Header block layout.
    localparam logic [8:0] BLOCK_LAST = 9'd511;
    localparam logic [8:0] NAME_MAX   = 9'd100;
    localparam logic [8:0] MODE_AT    = 9'd100;
    localparam logic [8:0] MODE_END   = 9'd108;
    localparam logic [8:0] SIZE_AT    = 9'd124;
    localparam logic [8:0] SIZE_END   = 9'd136;
    localparam logic [8:0] TYPE_AT    = 9'd156;

    // Characters of interest.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    // One queue entry: an optional entry or payload result followed by an
    // optional end-of-archive result.
    typedef struct packed {
        logic        has_main;
        logic [1:0]  main_kind;
        logic [1:0]  name_offset;
        logic [6:0]  name_length;
        logic [7:0]  entry_type;
        logic [23:0] entry_mode;
        logic [35:0] entry_size;
        logic [7:0]  payload_byte;
        logic        has_end;
        logic [1:0]  end_kind;
    } result_t;

endpackage

// ===== design/ustar_header_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ustar_header_stream_parser
// Walks a ustar archive one byte per item and reports entries and data.
// ----------------------------------------------------------------------------
// An accepted item passes the input register, then the parse logic into the
// result queue, before it reaches the result port.
// Throughput: one item per cycle while each item gives at most one result and
// m_ready keeps up; an item that gives two results shows them in turn.
// Reset: aresetn is synchronous and active low; it returns the parser to the
// start of a header block and empties the input register and result queue.

module ustar_header_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_archive_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [1:0]  m_name_offset,
    output logic [6:0]  m_name_length,
    output logic [7:0]  m_entry_type,
    output logic [23:0] m_entry_mode,
    output logic [35:0] m_entry_size,
    output logic [7:0]  m_payload_byte,
    output logic        m_last_of_run
);

    // The parser is in one of three phases: reading a 512-byte header,
    // walking an entry's data region (payload plus padding), or idle after
    // the all-zero end block until the final byte arrives.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_STOPPED
    } phase_t;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        fin_reg;

    // Parse state.
    phase_t      phase_reg,           phase_next;
    logic [8:0]  block_offset_reg,    block_offset_next;
    logic        all_zero_reg,        all_zero_next;
    logic        name_ended_reg,      name_ended_next;
    logic [6:0]  stripped_length_reg, stripped_length_next;
    logic        first_is_dot_reg,    first_is_dot_next;
    logic        second_is_slash_reg, second_is_slash_next;
    logic [7:0]  type_hold_reg,       type_hold_next;
    logic [23:0] mode_accum_reg,      mode_accum_next;
    logic        mode_stopped_reg,    mode_stopped_next;
    logic [35:0] size_accum_reg,      size_accum_next;
    logic        size_stopped_reg,    size_stopped_next;
    logic [35:0] payload_left_reg,    payload_left_next;
    logic [36:0] padded_left_reg,     padded_left_next;

    // Result queue: two entries, each holding everything one item produced.
    ushsp_pkg::result_t q_reg [2];
    logic        head_reg;
    logic        tail_reg;
    logic [1:0]  count_reg;
    logic        second_reg;

    logic               fire;
    logic               push;
    logic               pop;
    logic               clear_hdr;
    logic               is_digit;
    logic [1:0]         end_kind;
    logic [6:0]         ent_len;
    logic [1:0]         ent_off;
    logic [27:0]        padded_blocks;
    logic [36:0]        padded;
    ushsp_pkg::result_t res;
    ushsp_pkg::result_t head;
    logic               show_main;

    // The parse step fires when a byte waits in the input register and the
    // queue has room for the entry it may create. A new byte is taken when the input register
    // is empty or empties in the same cycle.
    assign fire    = in_valid_reg && (count_reg != 2'd2);
    assign s_ready = !in_valid_reg || fire;

    assign is_digit = (byte_reg >= ushsp_pkg::CHAR_ZERO) &&
                      (byte_reg <= ushsp_pkg::CHAR_SEVEN);

    // Name as reported: a leading "./" is dropped when something follows it.
    always_comb begin
        if ((stripped_length_reg >= 7'd2) && first_is_dot_reg && second_is_slash_reg) begin
            ent_off = 2'd2;
            ent_len = stripped_length_reg - 7'd2;
        end else begin
            ent_off = 2'd0;
            ent_len = stripped_length_reg;
        end
    end

    // Data region length rounded up to whole 512-byte blocks.
    assign padded_blocks = {1'b0, size_accum_reg[35:9]} +
                           28'(|size_accum_reg[8:0]);
    assign padded        = {padded_blocks, 9'd0};

    always_comb begin
        phase_next           = phase_reg;
        block_offset_next    = block_offset_reg;
        all_zero_next        = all_zero_reg;
        name_ended_next      = name_ended_reg;
        stripped_length_next = stripped_length_reg;
        first_is_dot_next    = first_is_dot_reg;
        second_is_slash_next = second_is_slash_reg;
        type_hold_next       = type_hold_reg;
        mode_accum_next      = mode_accum_reg;
        mode_stopped_next    = mode_stopped_reg;
        size_accum_next      = size_accum_reg;
        size_stopped_next    = size_stopped_reg;
        payload_left_next    = payload_left_reg;
        padded_left_next     = padded_left_reg;
        res                  = '0;
        end_kind             = ushsp_pkg::KIND_END;
        clear_hdr            = 1'b0;

        if (fire) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (byte_reg != ushsp_pkg::CHAR_NUL) begin
                        all_zero_next = 1'b0;
                    end
                    // Name: cut at the first NUL, trailing slashes do not count.
                    if ((block_offset_reg < ushsp_pkg::NAME_MAX) && !name_ended_reg) begin
                        if (byte_reg == ushsp_pkg::CHAR_NUL) begin
                            name_ended_next = 1'b1;
                        end else begin
                            if (byte_reg != ushsp_pkg::CHAR_SLASH) begin
                                stripped_length_next = block_offset_reg[6:0] + 7'd1;
                            end
                            if (block_offset_reg == 9'd0) begin
                                first_is_dot_next = (byte_reg == ushsp_pkg::CHAR_DOT);
                            end
                            if (block_offset_reg == 9'd1) begin
                                second_is_slash_next = (byte_reg == ushsp_pkg::CHAR_SLASH);
                            end
                        end
                    end
                    // Octal fields: digits shift in, blanks are skipped, and
                    // anything else freezes the field.
                    if ((block_offset_reg >= ushsp_pkg::MODE_AT) &&
                        (block_offset_reg < ushsp_pkg::MODE_END) && !mode_stopped_reg) begin
                        if (is_digit) begin
                            mode_accum_next = {mode_accum_reg[20:0], byte_reg[2:0]};
                        end else if ((byte_reg != ushsp_pkg::CHAR_SPACE) &&
                                     (byte_reg != ushsp_pkg::CHAR_NUL)) begin
                            mode_stopped_next = 1'b1;
                        end
                    end
                    if ((block_offset_reg >= ushsp_pkg::SIZE_AT) &&
                        (block_offset_reg < ushsp_pkg::SIZE_END) && !size_stopped_reg) begin
                        if (is_digit) begin
                            size_accum_next = {size_accum_reg[32:0], byte_reg[2:0]};
                        end else if ((byte_reg != ushsp_pkg::CHAR_SPACE) &&
                                     (byte_reg != ushsp_pkg::CHAR_NUL)) begin
                            size_stopped_next = 1'b1;
                        end
                    end
                    if (block_offset_reg == ushsp_pkg::TYPE_AT) begin
                        type_hold_next = byte_reg;
                    end

                    // Last byte of the header: an all-zero block stops the parser; otherwise report
                    // a named entry and set up the walk over its data region if it has one.
                    if (block_offset_reg == ushsp_pkg::BLOCK_LAST) begin
                        if (all_zero_next) begin
                            phase_next = PH_STOPPED;
                        end else begin
                            if (ent_len != 7'd0) begin
                                res.has_main    = 1'b1;
                                res.main_kind   = ushsp_pkg::KIND_ENTRY;
                                res.name_offset = ent_off;
                                res.name_length = ent_len;
                                res.entry_type  = type_hold_reg;
                                res.entry_mode  = mode_accum_reg;
                                res.entry_size  = size_accum_reg;
                            end
                            if (size_accum_reg != 36'd0) begin
                                phase_next        = PH_DATA;
                                payload_left_next = (ent_len != 7'd0) ? size_accum_reg : 36'd0;
                                padded_left_next  = padded;
                                end_kind          = ushsp_pkg::KIND_TRUNC;
                            end
                        end
                        clear_hdr = 1'b1;
                    end else begin
                        block_offset_next = block_offset_reg + 9'd1;
                    end
                end
                PH_DATA: begin
                    // Payload bytes are forwarded; padding is dropped.
                    if (payload_left_reg != 36'd0) begin
                        res.has_main      = 1'b1;
                        res.main_kind     = ushsp_pkg::KIND_PAYLOAD;
                        res.payload_byte  = byte_reg;
                        payload_left_next = payload_left_reg - 36'd1;
                    end
                    padded_left_next = padded_left_reg - 37'd1;
                    if (padded_left_reg == 37'd1) begin
                        payload_left_next = 36'd0;
                        phase_next        = PH_HEADER;
                        clear_hdr         = 1'b1;
                    end else begin
                        end_kind = ushsp_pkg::KIND_TRUNC;
                    end
                end
                default: begin
                    // After the end block, bytes are ignored until the final one.
                end
            endcase

            // The final byte closes the archive and rearms the parser.
            if (fin_reg) begin
                res.has_end       = 1'b1;
                res.end_kind      = end_kind;
                phase_next        = PH_HEADER;
                payload_left_next = 36'd0;
                padded_left_next  = 37'd0;
                clear_hdr         = 1'b1;
            end
        end

        if (clear_hdr) begin
            block_offset_next    = 9'd0;
            all_zero_next        = 1'b1;
            name_ended_next      = 1'b0;
            stripped_length_next = 7'd0;
            first_is_dot_next    = 1'b0;
            second_is_slash_next = 1'b0;
            type_hold_next       = 8'd0;
            mode_accum_next      = 24'd0;
            mode_stopped_next    = 1'b0;
            size_accum_next      = 36'd0;
            size_stopped_next    = 1'b0;
        end
    end

    assign push = fire && (res.has_main || res.has_end);

    // Result port: the head entry shows its main result first, then its end
    // result; the entry leaves the queue with the last of them.
    assign head      = q_reg[head_reg];
    assign show_main = head.has_main && !second_reg;
    assign m_valid   = (count_reg != 2'd0);

    always_comb begin
        if (show_main) begin
            m_kind         = head.main_kind;
            m_name_offset  = head.name_offset;
            m_name_length  = head.name_length;
            m_entry_type   = head.entry_type;
            m_entry_mode   = head.entry_mode;
            m_entry_size   = head.entry_size;
            m_payload_byte = head.payload_byte;
            m_last_of_run  = !head.has_end;
        end else begin
            m_kind         = head.end_kind;
            m_name_offset  = 2'd0;
            m_name_length  = 7'd0;
            m_entry_type   = 8'd0;
            m_entry_mode   = 24'd0;
            m_entry_size   = 36'd0;
            m_payload_byte = 8'd0;
            m_last_of_run  = 1'b1;
        end
    end

    assign pop = m_valid && m_ready && m_last_of_run;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            phase_reg           <= PH_HEADER;
            block_offset_reg    <= 9'd0;
            all_zero_reg        <= 1'b1;
            name_ended_reg      <= 1'b0;
            stripped_length_reg <= 7'd0;
            first_is_dot_reg    <= 1'b0;
            second_is_slash_reg <= 1'b0;
            type_hold_reg       <= 8'd0;
            mode_accum_reg      <= 24'd0;
            mode_stopped_reg    <= 1'b0;
            size_accum_reg      <= 36'd0;
            size_stopped_reg    <= 1'b0;
            payload_left_reg    <= 36'd0;
            padded_left_reg     <= 37'd0;
            head_reg            <= 1'b0;
            tail_reg            <= 1'b0;
            count_reg           <= 2'd0;
            second_reg          <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            phase_reg           <= phase_next;
            block_offset_reg    <= block_offset_next;
            all_zero_reg        <= all_zero_next;
            name_ended_reg      <= name_ended_next;
            stripped_length_reg <= stripped_length_next;
            first_is_dot_reg    <= first_is_dot_next;
            second_is_slash_reg <= second_is_slash_next;
            type_hold_reg       <= type_hold_next;
            mode_accum_reg      <= mode_accum_next;
            mode_stopped_reg    <= mode_stopped_next;
            size_accum_reg      <= size_accum_next;
            size_stopped_reg    <= size_stopped_next;
            payload_left_reg    <= payload_left_next;
            padded_left_reg     <= padded_left_next;
            if (push) begin
                tail_reg <= !tail_reg;
            end
            if (pop) begin
                head_reg <= !head_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
            if (m_valid && m_ready) begin
                second_reg <= !m_last_of_run;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_archive_byte;
            fin_reg  <= s_final_byte;
        end
        if (push) begin
            q_reg[tail_reg] <= res;
        end
    end

    // The queue never holds more than its two entries.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= 2'd2)
        else $error("result queue overflow");

    // While walking a data region, some data-region bytes always remain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (padded_left_reg != 37'd0))
        else $error("data phase with empty data region");

    // Payload still to forward never exceeds the data region left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, payload_left_reg} <= padded_left_reg))
        else $error("payload count exceeds data region");

    // A result taken that is not the last of its run is followed by another.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("second result of a run went missing");

endmodule
